### rtl/core/pra_pkg.sv
// Shared types and constants of the page run bitmap allocator.
// Used by pra_scan and by page_run_bitmap_allocator; depends on nothing.
`timescale 1ns / 1ps

package pra_pkg;

  localparam int PAGES      = 4096;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = PAGES / WORD_BITS;
  localparam int WORD_AW    = $clog2(MAP_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int PAGE_W     = $clog2(PAGES);
  localparam int CNT_W      = PAGE_W + 1;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 13;
  localparam int DELTA_W    = BIT_W + 1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WORD_AW-1:0]   widx_t;
  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [BIT_W-1:0]     bidx_t;

  localparam word_t WORD_ONES = '1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RESERVE = 2'd1,
    OP_TEST    = 2'd2,
    OP_FREE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_BAD_ARG  = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_PAST_END = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_LOAD,
    S_RANGE,
    S_DONE
  } state_t;

  // Result of scanning one bitmap word for a free run.
  typedef struct packed {
    logic  hit;
    bidx_t bit_idx;
    len_t  run_out;
  } scan_res_t;

endpackage

### rtl/core/pra_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module pra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/pra_scan.sv
// First-fit run search over one bitmap word, with the free run carried in
// from the words below. Depends on pra_pkg.
`timescale 1ns / 1ps

module pra_scan (
  input  pra_pkg::word_t     data,
  input  logic               first_word,
  input  pra_pkg::len_t      run_in,
  input  pra_pkg::len_t      run_len,
  output pra_pkg::scan_res_t res
);
  import pra_pkg::*;

  word_t d;
  word_t lowm;
  logic  all_free;
  logic  hit_b;
  bidx_t k;
  bidx_t hi;
  logic  any_used;

  always_comb begin
    // page zero is never handed out: treat it as used
    d            = first_word ? (data | WORD_BITS'(1)) : data;
    res.hit      = 1'b0;
    res.bit_idx  = '0;
    hi           = '0;
    any_used     = |d;
    lowm         = '0;
    all_free     = 1'b0;
    hit_b        = 1'b0;
    k            = '0;
    // lowest bit where the run reaches the requested length wins
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      lowm     = WORD_ONES >> (WORD_BITS - 1 - b);
      all_free = (d & lowm) == '0;
      if (run_len <= LEN_W'(b + 1)) begin
        k     = BIT_W'(LEN_W'(b + 1) - run_len);
        hit_b = (d & lowm & (WORD_ONES << k)) == '0;
      end else begin
        hit_b = all_free && ((run_in + LEN_W'(b + 1)) >= run_len);
      end
      if (hit_b) begin
        res.hit     = 1'b1;
        res.bit_idx = BIT_W'(b);
      end
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      if (d[b]) begin
        hi = BIT_W'(b);
      end
    end
    res.run_out = any_used ? LEN_W'(BIT_W'(WORD_BITS - 1) - hi)
                           : run_in + LEN_W'(WORD_BITS);
  end

endmodule

### rtl/core/page_run_bitmap_allocator.sv
// Top level of the page run bitmap allocator: request decode, bitmap scan
// and read-modify-write sequencer. Depends on pra_pkg, pra_ram, pra_scan.
`timescale 1ns / 1ps

// Page allocator over a used/free bitmap of PAGES pages of 4 KiB.
// Requests enter on the s_ channel: s_tuser carries the operation
// (allocate, reserve, test, free), s_tdata the byte address and run length.
// Every request returns exactly one result on the m_ channel with a status,
// the allocated byte address and the test answer.
// One request is worked on at a time. The bitmap sits in a 128 x 32 RAM with
// a registered read; the sequencer reads one word per cycle and writes the
// modified word back in the cycle its data arrives.
// Reserve, test, free: the range pass covers W words, W being the number of
// bitmap words the range spans (1 to 128).
// Allocate: first a scan of S words, S being the number of words scanned up
// to the first fitting run (1 to 128), then W words marked.
// Argument errors skip the scan and the range pass.
// Reset clears the count of pages in use to one (page zero) and a valid bit
// per bitmap word, so all pages read as free at once; no clearing pass.
// A finished result sits in an output register; when the receiver stalls,
// the block holds the next result until the register frees and accepts no
// new request meanwhile.
module page_run_bitmap_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [31:0] byte_address, [44:32] run_length, [47:45] zero
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [1:0] status, [33:2] result_address,
                                 // [34] range_in_use, [39:35] zero
);
  import pra_pkg::*;

  state_t state, state_next;

  op_t                 req_op;
  logic [ADDR_W-1:0]   req_addr;
  len_t                req_len;
  page_t               s_page;
  page_t               e_page;
  widx_t               word;
  len_t                run;
  cnt_t                pages_in_use;
  status_t             res_status;
  logic [ADDR_W-1:0]   res_addr;
  logic                res_in_use;
  logic [MAP_WORDS-1:0] vld;
  logic                rd_vld;

  logic   ram_we, ram_re;
  widx_t  ram_waddr, ram_raddr;
  word_t  ram_wdata, ram_rdata;
  word_t  rd_word;

  scan_res_t sres;

  logic [ADDR_W-PAGE_SHIFT-1:0] start_full;
  logic [ADDR_W-PAGE_SHIFT:0]   end_sum;
  logic   bad_arg, past_end, no_room;
  cnt_t   free_pages;
  page_t  range_end;
  page_t  hit_end;
  page_t  hit_start;
  bidx_t  lo_bit, hi_bit;
  word_t  mask;
  logic   set_op;
  logic [DELTA_W-1:0] delta;
  logic   slot_free;
  logic   last_word;

  pra_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  pra_scan u_scan (
    .data      (rd_word),
    .first_word(word == '0),
    .run_in    (run),
    .run_len   (req_len),
    .res       (sres)
  );

  // decode of the held request
  assign start_full = req_addr[ADDR_W-1:PAGE_SHIFT];
  assign bad_arg    = (req_addr == '0) || (req_addr[PAGE_SHIFT-1:0] != '0) ||
                      (req_len == '0);
  assign end_sum    = (ADDR_W - PAGE_SHIFT + 1)'(start_full) +
                      (ADDR_W - PAGE_SHIFT + 1)'(req_len);
  assign past_end   = end_sum > (ADDR_W - PAGE_SHIFT + 1)'(PAGES);
  assign free_pages = CNT_W'(PAGES) - pages_in_use;
  assign no_room    = free_pages < CNT_W'(req_len);
  assign range_end  = start_full[PAGE_W-1:0] + req_len[PAGE_W-1:0] - PAGE_W'(1);

  assign hit_end    = {word, sres.bit_idx};
  assign hit_start  = hit_end + PAGE_W'(1) - req_len[PAGE_W-1:0];

  // unwritten words read as all free
  assign rd_word    = rd_vld ? ram_rdata : '0;

  // mask of the range pages inside the current word
  assign lo_bit   = (word == s_page[PAGE_W-1:BIT_W]) ? s_page[BIT_W-1:0] : '0;
  assign hi_bit   = (word == e_page[PAGE_W-1:BIT_W]) ? e_page[BIT_W-1:0]
                                                     : BIT_W'(WORD_BITS - 1);
  assign mask     = (WORD_ONES << lo_bit) &
                    (WORD_ONES >> (BIT_W'(WORD_BITS - 1) - hi_bit));
  assign set_op   = req_op != OP_FREE;
  assign delta    = set_op ? DELTA_W'($countones(mask & ~rd_word))
                           : DELTA_W'($countones(mask & rd_word));
  assign last_word = word == e_page[PAGE_W-1:BIT_W];
  assign slot_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (req_op == OP_ALLOC) begin
          state_next = (req_len == '0 || no_room) ? S_DONE : S_SCAN;
        end else begin
          state_next = (bad_arg || past_end) ? S_DONE : S_LOAD;
        end
      end
      S_SCAN: begin
        if (sres.hit) state_next = S_LOAD;
        else if (word == widx_t'(MAP_WORDS - 1)) state_next = S_DONE;
      end
      S_LOAD:  state_next = S_RANGE;
      S_RANGE: begin
        if (last_word) state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = word;
    ram_wdata = set_op ? (rd_word | mask) : (rd_word & ~mask);
    case (state)
      S_IDLE:   s_tready = 1'b1;
      S_DECODE: ram_re = 1'b1;
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = word + widx_t'(1);
      end
      S_LOAD: begin
        ram_re    = 1'b1;
        ram_raddr = s_page[PAGE_W-1:BIT_W];
      end
      S_RANGE: begin
        ram_re    = !last_word;
        ram_raddr = word + widx_t'(1);
        ram_we    = req_op != OP_TEST;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      pages_in_use <= CNT_W'(1);
    end else begin
      if (ram_we) vld[ram_waddr] <= 1'b1;
      if (state == S_RANGE && req_op != OP_TEST) begin
        if (set_op) begin
          pages_in_use <= pages_in_use + CNT_W'(delta);
        end else if (pages_in_use < CNT_W'(delta)) begin
          pages_in_use <= '0;
        end else begin
          pages_in_use <= pages_in_use - CNT_W'(delta);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) rd_vld <= vld[ram_raddr];
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          req_op   <= op_t'(s_tuser);
          req_addr <= s_tdata[ADDR_W-1:0];
          req_len  <= s_tdata[ADDR_W+LEN_W-1:ADDR_W];
        end
      end
      S_DECODE: begin
        res_status <= ST_DONE;
        res_addr   <= '0;
        res_in_use <= req_op == OP_TEST;
        word       <= '0;
        run        <= '0;
        s_page     <= start_full[PAGE_W-1:0];
        e_page     <= range_end;
        if (req_op == OP_ALLOC) begin
          if (req_len == '0) res_status <= ST_BAD_ARG;
          else if (no_room)  res_status <= ST_NO_SPACE;
        end else if (bad_arg) begin
          res_status <= ST_BAD_ARG;
        end else if (past_end) begin
          res_status <= ST_PAST_END;
        end
      end
      S_SCAN: begin
        word <= word + widx_t'(1);
        run  <= sres.run_out;
        if (sres.hit) begin
          s_page   <= hit_start;
          e_page   <= hit_end;
          res_addr <= ADDR_W'(hit_start) << PAGE_SHIFT;
        end else if (word == widx_t'(MAP_WORDS - 1)) begin
          res_status <= ST_NO_SPACE;
        end
      end
      S_LOAD: word <= s_page[PAGE_W-1:BIT_W];
      S_RANGE: begin
        word <= word + widx_t'(1);
        // any free page in the range clears the test answer
        if (req_op == OP_TEST && (rd_word & mask) != mask) res_in_use <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && slot_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && slot_free) begin
      m_tdata <= {5'b0, res_in_use, res_addr, res_status};
    end
  end

  // read and write of the same word in one cycle would return stale data
  assert property (@(posedge clk) disable iff (rst)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("bitmap read and write collide on one word");

  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_RANGE)
    else $error("bitmap written outside the range pass");

  assert property (@(posedge clk) disable iff (rst)
    pages_in_use != '0 && pages_in_use <= CNT_W'(PAGES))
    else $error("pages in use count out of bounds");

  assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && sres.hit |=> state == S_LOAD && s_page != '0)
    else $error("allocation hit page zero or lost its run");

endmodule
